[sv/audio_peak_normalizer_assert.svh]
// Assertion macros used by the audio peak normalizer RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef AUDIO_PEAK_NORMALIZER_ASSERT_SVH
`define AUDIO_PEAK_NORMALIZER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define APN_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define APN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/apn_pkg.sv]
// Package for the audio peak normalizer: widths, constants, sequencer states
// and the divider status struct. No dependencies.
package apn_pkg;

	localparam int SAMPLE_W = 16;
	localparam int PEAK_W   = 15;
	// Magnitude times full scale stays below 2**30.
	localparam int NUM_W    = 30;
	localparam int STEP_W   = 5;

	localparam logic [PEAK_W-1:0]   FULL_SCALE = 15'h7FFF;
	localparam logic [SAMPLE_W-1:0] MOST_NEG   = 16'h8000;
	localparam logic [SAMPLE_W-1:0] MOST_POS   = 16'h7FFF;

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_READ,
		ST_LOAD,
		ST_DIV
	} apn_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[sv/audio_peak_normalizer.sv]
// Audio peak normalizer: collects a block of signed 16-bit samples, then scales each by 32767/peak.
// Collection takes one request per cycle. Draining handles one sample at a time: RAM read,
// operand setup, 30 quotient bits from the divider, capture; a zero-peak block skips the
// divider. Results cannot be stalled. Reset (arst_n low, asynchronous) empties the block.
//
// Depends on apn_pkg, apn_ram, apn_div and audio_peak_normalizer_assert.svh.
`include "audio_peak_normalizer_assert.svh"

module audio_peak_normalizer import apn_pkg::*; #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic                       block_end,
	output logic                       strobe,
	output logic signed [SAMPLE_W-1:0] sample_out,
	output logic        [PEAK_W-1:0]   peak_level,
	output logic                       run_last
);

	// Store address width and a count wide enough to hold MAX_SAMPLES itself.
	localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);

	apn_state_t          state_q;
	apn_state_t          state_d;
	logic [CNT_W-1:0]    fill_q;
	logic [ADDR_W-1:0]   k_q;
	logic [PEAK_W-1:0]   peak_q;
	logic                sign_q;

	logic                accept;
	logic [CNT_W-1:0]    fill_next;
	logic                block_done;
	logic                last_item;
	logic [SAMPLE_W-1:0] s_u;
	logic [SAMPLE_W-1:0] s_neg;
	logic [PEAK_W-1:0]   abs_in;

	logic [SAMPLE_W-1:0] rd_data;
	logic [SAMPLE_W-1:0] mag;
	logic [NUM_W-1:0]    numer;
	logic [NUM_W-1:0]    div_quot;
	div_stat_t           div_stat;

	logic                ram_we;
	logic                div_start;
	logic                emit;
	logic [SAMPLE_W-1:0] result;
	logic [SAMPLE_W-1:0] sat_val;

	logic                strobe_q;
	logic [SAMPLE_W-1:0] sample_out_q;
	logic [PEAK_W-1:0]   peak_level_q;
	logic                run_last_q;

	// A request is taken only while the sequencer is collecting.
	assign busy   = (state_q != ST_COLLECT);
	assign accept = start && !busy;

	// The block ends on the marked sample or on the one that fills the store.
	assign fill_next  = fill_q + CNT_W'(1);
	assign block_done = block_end || (fill_next == CNT_W'(MAX_SAMPLES));
	assign last_item  = (k_q == ADDR_W'(fill_q - CNT_W'(1)));

	// Absolute value for peak tracking; the most negative sample counts as
	// full scale so that the peak always fits in fifteen bits.
	always_comb begin
		s_u    = sample_in;
		s_neg  = ~s_u + SAMPLE_W'(1);
		abs_in = s_u[SAMPLE_W-1] ? ((s_u == MOST_NEG) ? FULL_SCALE : s_neg[PEAK_W-1:0])
		                         : s_u[PEAK_W-1:0];
	end

	apn_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata (s_u),
		.raddr (k_q),
		.rdata (rd_data)
	);

	// The dividend is the sample magnitude times 32767, formed as a shift and
	// a subtract. The magnitude of the most negative sample is 32768 here,
	// which is exact; the sign is put back after the division.
	always_comb begin
		mag   = rd_data[SAMPLE_W-1] ? (~rd_data + SAMPLE_W'(1)) : rd_data;
		numer = NUM_W'({mag, {PEAK_W{1'b0}}} - {{PEAK_W{1'b0}}, mag});
	end

	apn_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.numer   (numer),
		.divisor (peak_q),
		.quot    (div_quot),
		.stat    (div_stat)
	);

	// The quotient magnitude truncates toward zero. A positive result clips at
	// 32767, a negative one at -32768.
	always_comb begin
		if (!sign_q) begin
			sat_val = (|div_quot[NUM_W-1:PEAK_W]) ? MOST_POS : {1'b0, div_quot[PEAK_W-1:0]};
		end else if ((|div_quot[NUM_W-1:PEAK_W+1]) ||
		             (div_quot[PEAK_W] && (|div_quot[PEAK_W-1:0]))) begin
			sat_val = MOST_NEG;
		end else begin
			sat_val = ~div_quot[SAMPLE_W-1:0] + SAMPLE_W'(1);
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_COLLECT: begin
				if (accept && block_done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				// With a zero peak every sample is zero and passes unchanged.
				if (peak_q == '0) begin
					state_d = last_item ? ST_COLLECT : ST_READ;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = last_item ? ST_COLLECT : ST_READ;
				end
			end
			default: begin
				state_d = ST_COLLECT;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		ram_we    = 1'b0;
		div_start = 1'b0;
		emit      = 1'b0;
		result    = sat_val;
		unique case (state_q)
			ST_COLLECT: begin
				ram_we = accept;
			end
			ST_READ: begin
			end
			ST_LOAD: begin
				if (peak_q == '0) begin
					emit   = 1'b1;
					result = rd_data;
				end else begin
					div_start = 1'b1;
				end
			end
			ST_DIV: begin
				emit = div_stat.done;
			end
			default: begin
			end
		endcase
	end

	// Control state: sequencer, fill count, drain index and running peak.
	// The count and the peak hold through the drain and clear with the last
	// result of the block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_COLLECT;
			fill_q   <= '0;
			k_q      <= '0;
			peak_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			if (accept) begin
				fill_q <= fill_next;
				if (abs_in > peak_q) begin
					peak_q <= abs_in;
				end
			end
			if (emit) begin
				if (last_item) begin
					fill_q <= '0;
					peak_q <= '0;
					k_q    <= '0;
				end else begin
					k_q <= k_q + ADDR_W'(1);
				end
			end
		end
	end

	// Payload registers: operand sign and the result held on the ports.
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			sign_q <= rd_data[SAMPLE_W-1];
		end
		if (emit) begin
			sample_out_q <= result;
			peak_level_q <= peak_q;
			run_last_q   <= last_item;
		end
	end

	assign strobe     = strobe_q;
	assign sample_out = sample_out_q;
	assign peak_level = peak_level_q;
	assign run_last   = run_last_q;

	// Results of one block are always separated by a read cycle.
	`APN_ASSERT_NEXT(a_strobe_single, strobe_q, !strobe_q, "result strobe held two cycles")
	// A request that ends the block starts the drain on the next cycle.
	`APN_ASSERT_NEXT(a_end_starts_drain, accept && block_done, busy, "block end did not start drain")
	// The last result of a block leaves the block ready for a new request.
	`APN_ASSERT_IMPL(a_last_frees, strobe_q && run_last_q, !busy, "busy after last result")
	// The divider only runs while the block is draining.
	`APN_ASSERT_IMPL(a_div_idle, state_q == ST_COLLECT, !div_stat.busy, "divider active while collecting")

endmodule

[sv/apn_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module apn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/apn_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on apn_pkg for widths and the status struct.
module apn_div import apn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  numer,
	input  logic [PEAK_W-1:0] divisor,
	output logic [NUM_W-1:0]  quot,
	output div_stat_t         stat
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [NUM_W-1:0]  work_q;
	logic [PEAK_W-1:0] rem_q;
	logic [PEAK_W-1:0] dvs_q;

	logic [PEAK_W:0]   shifted;
	logic              ge;
	logic [PEAK_W:0]   diff;

	// The remainder stays below the divisor, so it fits in PEAK_W bits.
	always_comb begin
		shifted = {rem_q, work_q[NUM_W-1]};
		ge      = (shifted >= {1'b0, dvs_q});
		diff    = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == STEP_W'(NUM_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= numer;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[NUM_W-2:0], ge};
			rem_q  <= ge ? diff[PEAK_W-1:0] : shifted[PEAK_W-1:0];
		end
	end

	assign quot      = work_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[sim/tb_top.sv]
// Self-checking testbench for audio_peak_normalizer: directed blocks, full-store blocks and
// random blocks under several sender idle rates, each result checked against a local predictor.
// Depends on apn_pkg and the audio_peak_normalizer RTL.
`timescale 1ns / 100ps

module tb_top import apn_pkg::*;;

	// Store depth used for this run; it matches the block's default.
	localparam int BLOCK_CAP = 64;
	// Cycles with neither a request nor a result accepted before the run is abandoned.
	// This is many times the longest legitimate quiet stretch of a full 64-sample drain.
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_TAIL = 40;

	// One normalized sample as the block should present it.
	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic [PEAK_W-1:0]          peak;
		logic                       last;
	} norm_result_t;

	logic                       clk;
	logic                       arst_n    = 1'b0;
	logic                       start     = 1'b0;
	logic                       busy;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic                       block_end = 1'b0;
	logic                       strobe;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic [PEAK_W-1:0]          peak_level;
	logic                       run_last;

	// Predictor state: the samples of the block being collected and its running peak.
	logic signed [SAMPLE_W-1:0] block_samples[$];
	logic [PEAK_W-1:0]          block_peak = '0;
	// Normalized samples that the block owes us, oldest first.
	norm_result_t               pending_norm[$];

	int error_count = 0;
	int quiet_cycles = 0;
	// Percentage of requests that are preceded by a random idle gap.
	int sender_idle_pct = 0;

	audio_peak_normalizer #(
		.MAX_SAMPLES(BLOCK_CAP)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sample_in (sample_in),
		.block_end (block_end),
		.strobe    (strobe),
		.sample_out(sample_out),
		.peak_level(peak_level),
		.run_last  (run_last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Absolute value on 15 bits; the most negative sample is clamped to full scale.
	function automatic logic [PEAK_W-1:0] sample_magnitude(input logic signed [SAMPLE_W-1:0] s);
		int v;
		v = s;
		if (v < 0)
			v = -v;
		if (v > int'(FULL_SCALE))
			v = int'(FULL_SCALE);
		return PEAK_W'(v);
	endfunction

	// Exact integer form of sample * 32767 / peak, truncated toward zero and saturated.
	// A zero peak means the block was silent, and samples pass through as they are.
	function automatic logic signed [SAMPLE_W-1:0] normalize_sample(
		input logic signed [SAMPLE_W-1:0] s,
		input logic [PEAK_W-1:0]          peak
	);
		longint quot;
		if (peak == '0)
			return s;
		quot = (longint'(s) * longint'(FULL_SCALE)) / longint'(peak);
		if (quot > longint'($signed(MOST_POS)))
			quot = longint'($signed(MOST_POS));
		if (quot < longint'($signed(MOST_NEG)))
			quot = longint'($signed(MOST_NEG));
		return SAMPLE_W'(quot);
	endfunction

	// Called once for every request the block takes. When the request closes the block,
	// either by its end mark or by filling the store, the whole block is normalized
	// and queued, and the collection state starts over.
	function automatic void absorb_sample(input logic signed [SAMPLE_W-1:0] s, input logic mark);
		norm_result_t r;
		logic [PEAK_W-1:0] mag;
		mag = sample_magnitude(s);
		block_samples.push_back(s);
		if (mag > block_peak)
			block_peak = mag;
		if (mark || block_samples.size() == BLOCK_CAP) begin
			foreach (block_samples[k]) begin
				r.sample = normalize_sample(block_samples[k], block_peak);
				r.peak   = block_peak;
				r.last   = (k == block_samples.size() - 1);
				pending_norm.push_back(r);
			end
			block_samples.delete();
			block_peak = '0;
		end
	endfunction

	// Presents one request and returns at the clock edge that accepts it. The request
	// stays on the ports afterward; the next call overwrites it in the same step, so
	// start is never dropped and raised again within one time step. An idle gap, when
	// the roll asks for one, lowers start first and raises it again after a random wait.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic mark);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start     <= 1'b1;
		sample_in <= s;
		block_end <= mark;
		// busy is read before this edge's updates land, so the test matches the
		// block's own view of the handshake.
		do
			@(posedge clk);
		while (busy);
		absorb_sample(s, mark);
	endtask

	// Random sample whose magnitude is set by an arithmetic shift, so blocks with small
	// peaks are as common as loud ones. A small share are the range extremes.
	function automatic logic signed [SAMPLE_W-1:0] random_sample(input int shift);
		logic signed [SAMPLE_W-1:0] raw;
		case ($urandom_range(24))
			0: return $signed(MOST_NEG);
			1: return $signed(MOST_POS);
			default: begin
				raw = $signed(SAMPLE_W'($urandom));
				return raw >>> shift;
			end
		endcase
	endfunction

	// Sends one block of random content. A full-length block may carry the end mark on
	// its final sample or not; the store filling up has to close it either way.
	task automatic send_random_block(input int len);
		int  shift;
		bit  silent;
		logic mark;
		shift  = $urandom_range(0, 15);
		silent = ($urandom_range(19) == 0);
		for (int k = 0; k < len; k++) begin
			if (k != len - 1)
				mark = 1'b0;
			else if (len == BLOCK_CAP)
				mark = 1'($urandom_range(1));
			else
				mark = 1'b1;
			send_sample(silent ? '0 : random_sample(shift), mark);
		end
	endtask

	// Single-sample blocks: each is its own peak, so full scale comes back unchanged and a small one scales up.
	task automatic test_single_sample;
		send_sample($signed(MOST_POS), 1'b1);
		send_sample(16'sd5, 1'b1);
	endtask

	// The most negative sample sets the peak to full scale and itself stays at the
	// bottom of the range; a small sample in the same block scales by one.
	task automatic test_most_negative;
		send_sample($signed(MOST_NEG), 1'b1);
		send_sample($signed(MOST_NEG), 1'b0);
		send_sample($signed(MOST_POS), 1'b0);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd1, 1'b1);
	endtask

	// Silent blocks have a zero peak, so the samples must pass through untouched.
	task automatic test_zero_peak;
		send_sample(16'sd0, 1'b1);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd0, 1'b1);
	endtask

	// Small peaks stretch samples up to full scale, and odd ratios show whether the
	// quotient truncates toward zero for negative samples.
	task automatic test_small_peak;
		send_sample(16'sd1, 1'b0);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd0, 1'b1);
		send_sample(16'sd2, 1'b0);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd1, 1'b1);
		send_sample(16'sd12345, 1'b0);
		send_sample(-16'sd7, 1'b0);
		send_sample(-16'sd12344, 1'b0);
		send_sample(16'sd300, 1'b1);
	endtask

	// Blocks that reach the store depth: one closed only by filling up, one whose
	// final sample also carries the end mark, then a short block to show that the
	// collection restarted cleanly.
	task automatic test_store_full;
		int shift;
		shift = $urandom_range(0, 8);
		for (int k = 0; k < BLOCK_CAP; k++)
			send_sample(random_sample(shift), 1'b0);
		for (int k = 0; k < BLOCK_CAP; k++)
			send_sample(random_sample(0), k == BLOCK_CAP - 1);
		send_sample(-16'sd3, 1'b1);
	endtask

	// Random blocks, mostly short, some mid-length and now and then a full store.
	task automatic test_random_blocks(input int item_goal, input int idle_pct);
		int sent;
		int len;
		sent = 0;
		sender_idle_pct = idle_pct;
		while (sent < item_goal) begin
			case ($urandom_range(29))
				0:       len = BLOCK_CAP;
				1, 2, 3: len = $urandom_range(13, BLOCK_CAP - 1);
				default: len = $urandom_range(1, 12);
			endcase
			send_random_block(len);
			sent += len;
		end
	endtask

	// Every strobe is one result: it must match the oldest normalized sample owed,
	// field by field. A strobe with nothing owed is a failure of its own.
	always @(posedge clk) begin
		norm_result_t want;
		if (arst_n && strobe) begin
			if (pending_norm.size() == 0) begin
				$error("unexpected result: sample_out=%0d peak_level=%0d run_last=%0b",
					sample_out, peak_level, run_last);
				error_count++;
			end else begin
				want = pending_norm.pop_front();
				if (sample_out !== want.sample) begin
					$error("sample_out: expected %0d, got %0d", want.sample, sample_out);
					error_count++;
				end
				if (peak_level !== want.peak) begin
					$error("peak_level: expected %0d, got %0d", want.peak, peak_level);
					error_count++;
				end
				if (run_last !== want.last) begin
					$error("run_last: expected %0b, got %0b", want.last, run_last);
					error_count++;
				end
			end
		end
	end

	// Watchdog: any accepted request or result counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed blocks with a steady sender.
		sender_idle_pct = 0;
		test_single_sample();
		test_most_negative();
		test_zero_peak();
		test_small_peak();

		// Full-store blocks with light sender gaps.
		sender_idle_pct = 10;
		test_store_full();

		// Random phases: back to back, a mostly idle sender, then occasional gaps.
		test_random_blocks(60, 0);
		test_random_blocks(60, 66);
		test_random_blocks(60, 10);

		start <= 1'b0;
		while (pending_norm.size() != 0)
			@(posedge clk);
		// Let any stray result surface before the verdict.
		repeat (DRAIN_TAIL) @(posedge clk);

		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
